/* design/mpas_pkg.sv */
// Shared types, constants and the control program of the arctan series core.
package mpas_pkg;

   localparam int MAX_TERMS_DEFAULT = 4096;
   localparam int RESULT_FRAC_BITS  = 60;

   localparam int TERM_COUNT_W = 13;
   localparam int TERM_LIMIT   = 2 ** TERM_COUNT_W - 1;
   localparam int X_W          = 32;
   localparam int RESULT_W     = 64;
   localparam int Q_FRAC       = 62;
   localparam int MAG_W        = 63;
   localparam int PROD_W       = Q_FRAC + MAG_W;
   localparam int HALF_W       = 32;
   localparam int QUO_W        = 64;
   localparam int DIV_BITS     = 2;

   localparam int ATAN_SH = Q_FRAC - RESULT_FRAC_BITS;
   localparam int PI_SH   = Q_FRAC - 2 - RESULT_FRAC_BITS;

   localparam logic [RESULT_W-1:0] ATAN_HALF =
      (ATAN_SH == 0) ? '0 : (RESULT_W'(1) << (ATAN_SH - 1));
   localparam logic [RESULT_W-1:0] PI_HALF =
      (PI_SH == 0) ? '0 : (RESULT_W'(1) << (PI_SH - 1));

   localparam logic [MAG_W-1:0] ONE_Q62   = MAG_W'(1) << Q_FRAC;
   localparam logic [MAG_W-1:0] P0_FIFTH  = (ONE_Q62 + MAG_W'(2)) / MAG_W'(5);
   localparam logic [MAG_W-1:0] P0_239TH  = (ONE_Q62 + MAG_W'(119)) / MAG_W'(239);
   localparam logic [PROD_W-1:0] ROUND_Q62 = PROD_W'(1) << (Q_FRAC - 1);

   localparam logic signed [X_W-1:0] X_ONE       = 32'sh4000_0000;
   localparam logic signed [X_W-1:0] X_MINUS_ONE = 32'shC000_0000;

   localparam int SUB_W = 6;
   localparam logic [SUB_W-1:0] MUL_LAST = SUB_W'(5);
   localparam logic [SUB_W-1:0] DIV_LAST = SUB_W'(QUO_W / DIV_BITS + 1);

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] ST_IDLE    = 4'd0;
   localparam logic [STEP_W-1:0] ST_SQUARE  = 4'd1;
   localparam logic [STEP_W-1:0] ST_TEST    = 4'd2;
   localparam logic [STEP_W-1:0] ST_DIVIDE  = 4'd3;
   localparam logic [STEP_W-1:0] ST_POWER   = 4'd4;
   localparam logic [STEP_W-1:0] ST_CLAMP   = 4'd5;
   localparam logic [STEP_W-1:0] ST_PASS    = 4'd6;
   localparam logic [STEP_W-1:0] ST_RELOAD  = 4'd7;
   localparam logic [STEP_W-1:0] ST_PI_DIFF = 4'd8;
   localparam logic [STEP_W-1:0] ST_ABS     = 4'd9;
   localparam logic [STEP_W-1:0] ST_ROUND   = 4'd10;
   localparam logic [STEP_W-1:0] ST_OUT     = 4'd11;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_SQUARE,
      OP_NOP,
      OP_DIVIDE,
      OP_POWER,
      OP_CLAMP,
      OP_RELOAD,
      OP_PI_DIFF,
      OP_ABS,
      OP_ROUND,
      OP_OUT
   } op_type;

   typedef enum logic [2:0] {
      JC_NEVER,
      JC_ALWAYS,
      JC_LOOP_END,
      JC_ATAN,
      JC_PASS2
   } jump_cond_type;

   typedef struct packed {
      op_type              op;
      jump_cond_type       cond;
      logic [STEP_W-1:0]   target;
   } ctrl_word_type;

   function automatic ctrl_word_type ctrl_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      unique case (step)
         ST_IDLE:    cw = '{OP_IDLE,    JC_NEVER,    ST_IDLE};
         ST_SQUARE:  cw = '{OP_SQUARE,  JC_NEVER,    ST_IDLE};
         ST_TEST:    cw = '{OP_NOP,     JC_LOOP_END, ST_CLAMP};
         ST_DIVIDE:  cw = '{OP_DIVIDE,  JC_NEVER,    ST_IDLE};
         ST_POWER:   cw = '{OP_POWER,   JC_ALWAYS,   ST_TEST};
         ST_CLAMP:   cw = '{OP_CLAMP,   JC_ATAN,     ST_ABS};
         ST_PASS:    cw = '{OP_NOP,     JC_PASS2,    ST_PI_DIFF};
         ST_RELOAD:  cw = '{OP_RELOAD,  JC_ALWAYS,   ST_SQUARE};
         ST_PI_DIFF: cw = '{OP_PI_DIFF, JC_NEVER,    ST_IDLE};
         ST_ABS:     cw = '{OP_ABS,     JC_NEVER,    ST_IDLE};
         ST_ROUND:   cw = '{OP_ROUND,   JC_NEVER,    ST_IDLE};
         ST_OUT:     cw = '{OP_OUT,     JC_ALWAYS,   ST_IDLE};
         default:    cw = '{OP_NOP,     JC_ALWAYS,   ST_IDLE};
      endcase
      return cw;
   endfunction

endpackage

/* design/machin_pi_arctan_series_core.sv */
// Microcoded arctan Taylor series and Machin pi core.
//
// Use: an item on req_ (func, x_value, term_count) is taken when req_valid is
// high and req_stall low; req_stall is low only while the sequencer waits at
// its idle step. Each item gives one rsp_result_value item on rsp_, held in
// an output register until rsp_valid is high and rsp_stall low.
// term_count is saturated to MAX_TERMS and to 8191; arctan mode sums
// one series, pi mode two (1/5 and 1/239).
// Each term costs a divide by 2i-1 (two quotient bits per cycle)
// and a Q1.62 multiply built from four 32x32 partial products,
// plus one loop test step. One item is worked on at a time; the next item is
// taken as soon as the result is in the output register. If rsp_stall holds
// an earlier result, the final step waits until the register frees.
// Reset (synchronous) returns the sequencer to idle and drops rsp_valid;
// the datapath registers are not reset.
module machin_pi_arctan_series_core #(
   parameter int MAX_TERMS = mpas_pkg::MAX_TERMS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic signed [mpas_pkg::X_W-1:0]      req_x_value,
   input  logic [mpas_pkg::TERM_COUNT_W-1:0]    req_term_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [mpas_pkg::RESULT_W-1:0] rsp_result_value
);
   import mpas_pkg::*;

   localparam int N_MAX = (MAX_TERMS < TERM_LIMIT) ? MAX_TERMS : TERM_LIMIT;
   localparam int NW    = $clog2(N_MAX + 1);
   localparam int DW    = NW + 1;

   ctrl_word_type cw;

   logic [STEP_W-1:0] pc_ff, pc_in;
   logic [SUB_W-1:0]  sub_ff, sub_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_W-1:0] rsp_value_ff, rsp_value_in;

   logic              func_ff, func_in;
   logic              pass_ff, pass_in;
   logic              neg_ff, neg_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [NW-1:0]     im1_ff, im1_in;
   logic [MAG_W-1:0]  p_ff, p_in;
   logic [MAG_W-1:0]  sq_ff, sq_in;
   logic [MAG_W-1:0]  a5_ff, a5_in;
   logic signed [RESULT_W-1:0] acc_ff, acc_in;
   logic [2*HALF_W-1:0] pp_ff, pp_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DW-1:0]     rem_ff, rem_in;

   logic req_fire, rsp_take, out_free, step_done, jump_taken;
   logic signed [X_W-1:0] x_clamped;
   logic [X_W-1:0]        x_mag;
   logic [MAG_W-1:0]      p0_atan;
   logic [NW-1:0]         n_sat;
   logic [MAG_W-1:0]      mul_b;
   logic [1:0]            pp_k;
   logic [HALF_W-1:0]     a_half, b_half;
   logic [2*HALF_W-1:0]   pp_prod;
   logic [PROD_W-1:0]     pp_shifted;
   logic [MAG_W-1:0]      mul_result;
   logic [DW-1:0]         divisor;
   logic [QUO_W-1:0]      div_q;
   logic [DW-1:0]         div_r;
   logic [RESULT_W-1:0]   rnd_sum;

   assign cw        = ctrl_rom(pc_ff);
   assign req_stall = (cw.op != OP_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

   // argument clamp and start power
   assign x_clamped = (req_x_value > X_ONE) ? X_ONE :
                      (req_x_value < X_MINUS_ONE) ? X_MINUS_ONE : req_x_value;
   assign x_mag     = x_clamped[X_W-1] ? X_W'(-x_clamped) : x_clamped;
   assign p0_atan   = {x_mag[X_W-2:0], {(MAG_W - X_W + 1){1'b0}}};
   assign n_sat     = (32'(req_term_count) > 32'(N_MAX)) ? NW'(N_MAX)
                                                         : NW'(req_term_count);

   // multiplier: one 32x32 partial product per cycle, each registered in pp_ff before it is accumulated
   assign mul_b      = (cw.op == OP_SQUARE) ? p_ff : sq_ff;
   assign a_half     = sub_ff[1] ? HALF_W'(p_ff[MAG_W-1:HALF_W]) : p_ff[HALF_W-1:0];
   assign b_half     = sub_ff[0] ? HALF_W'(mul_b[MAG_W-1:HALF_W]) : mul_b[HALF_W-1:0];
   assign pp_prod    = a_half * b_half;
   assign pp_k       = sub_ff[1:0] - 2'd1;
   assign pp_shifted = (pp_k == 2'd0) ? PROD_W'(pp_ff) :
                       (pp_k == 2'd3) ? (PROD_W'(pp_ff) << (2 * HALF_W)) :
                                        (PROD_W'(pp_ff) << HALF_W);
   assign mul_result = prod_ff[Q_FRAC +: MAG_W];

   // divider: restoring, two quotient bits per cycle
   assign divisor = {im1_ff, 1'b1};

   always_comb begin
      logic [DW:0] trial;
      div_q = quo_ff;
      div_r = rem_ff;
      for (int b = 0; b < DIV_BITS; b++) begin
         trial = {div_r, div_q[QUO_W-1]};
         div_q = {div_q[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial    = trial - {1'b0, divisor};
            div_q[0] = 1'b1;
         end
         div_r = trial[DW-1:0];
      end
   end

   assign rnd_sum = $unsigned(acc_ff) + (func_ff ? PI_HALF : ATAN_HALF);

   // sequencer
   always_comb begin
      unique case (cw.op)
         OP_IDLE:             step_done = req_fire;
         OP_SQUARE, OP_POWER: step_done = (sub_ff == MUL_LAST);
         OP_DIVIDE:           step_done = (sub_ff == DIV_LAST);
         OP_OUT:              step_done = out_free;
         default:             step_done = 1'b1;
      endcase

      unique case (cw.cond)
         JC_NEVER:    jump_taken = 1'b0;
         JC_ALWAYS:   jump_taken = 1'b1;
         JC_LOOP_END: jump_taken = (im1_ff >= n_ff);
         JC_ATAN:     jump_taken = !func_ff;
         JC_PASS2:    jump_taken = pass_ff;
         default:     jump_taken = 1'b0;
      endcase

      if (step_done) begin
         pc_in  = jump_taken ? cw.target : pc_ff + STEP_W'(1);
         sub_in = '0;
      end else if (cw.op == OP_SQUARE || cw.op == OP_POWER || cw.op == OP_DIVIDE) begin
         pc_in  = pc_ff;
         sub_in = sub_ff + SUB_W'(1);
      end else begin
         pc_in  = pc_ff;
         sub_in = sub_ff;
      end
   end

   // datapath
   always_comb begin
      func_in      = func_ff;
      pass_in      = pass_ff;
      neg_in       = neg_ff;
      n_in         = n_ff;
      im1_in       = im1_ff;
      p_in         = p_ff;
      sq_in        = sq_ff;
      a5_in        = a5_ff;
      acc_in       = acc_ff;
      pp_in        = pp_prod;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;

      unique case (cw.op)
         OP_IDLE: begin
            if (req_fire) begin
               func_in = req_func;
               pass_in = 1'b0;
               neg_in  = !req_func && x_clamped[X_W-1];
               n_in    = n_sat;
               im1_in  = '0;
               acc_in  = '0;
               p_in    = req_func ? P0_FIFTH : p0_atan;
            end
         end
         OP_SQUARE, OP_POWER: begin
            if (sub_ff == '0) begin
               prod_in = ROUND_Q62;
            end else if (sub_ff < MUL_LAST) begin
               prod_in = prod_ff + pp_shifted;
            end else if (cw.op == OP_SQUARE) begin
               sq_in = mul_result;
            end else begin
               p_in   = mul_result;
               im1_in = im1_ff + NW'(1);
            end
         end
         OP_DIVIDE: begin
            if (sub_ff == '0) begin
               quo_in = QUO_W'(p_ff) + QUO_W'(im1_ff);
               rem_in = '0;
            end else if (sub_ff < DIV_LAST) begin
               quo_in = div_q;
               rem_in = div_r;
            end else begin
               acc_in = im1_ff[0] ? acc_ff - $signed(quo_ff) : acc_ff + $signed(quo_ff);
            end
         end
         OP_CLAMP: begin
            acc_in = acc_ff[RESULT_W-1] ? '0 : acc_ff;
         end
         OP_RELOAD: begin
            a5_in   = acc_ff[MAG_W-1:0];
            p_in    = P0_239TH;
            acc_in  = '0;
            im1_in  = '0;
            pass_in = 1'b1;
         end
         OP_PI_DIFF: begin
            acc_in = $signed({a5_ff[MAG_W-2:0], 2'b00}) - acc_ff;
         end
         OP_ABS: begin
            neg_in = neg_ff ^ acc_ff[RESULT_W-1];
            acc_in = acc_ff[RESULT_W-1] ? -acc_ff : acc_ff;
         end
         OP_ROUND: begin
            acc_in = func_ff ? $signed(rnd_sum >> PI_SH) : $signed(rnd_sum >> ATAN_SH);
         end
         OP_OUT: begin
            if (out_free) begin
               rsp_value_in = neg_ff ? -acc_ff : acc_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ST_IDLE;
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff      <= func_in;
      pass_ff      <= pass_in;
      neg_ff       <= neg_in;
      n_ff         <= n_in;
      im1_ff       <= im1_in;
      p_ff         <= p_in;
      sq_ff        <= sq_in;
      a5_ff        <= a5_in;
      acc_ff       <= acc_in;
      pp_ff        <= pp_in;
      prod_ff      <= prod_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

/* design/mpas_checker.sv */
// Port-level checks for the arctan series core, bound to the top level.
module mpas_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [mpas_pkg::RESULT_W-1:0] rsp_result_value
);

   // a held result item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value))
      else $error("result item changed while stalled");

   // an accepted item keeps the core busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("core took no time over an item");

   // a new result appears only as the sequencer finishes an item
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall) && !req_stall)
      else $error("result item without finished work");

   // reset leaves the core idle with nothing to deliver
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("core not idle after reset");

endmodule

bind machin_pi_arctan_series_core mpas_checker u_mpas_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_value (rsp_result_value)
);
